// ===== src/phe_pkg.sv =====
// Shared types and constants for the piecewise hazard evaluator.
// Request and response payload structs, table row layout, register map.
// No dependencies.
package phe_pkg;

	localparam int TIME_W  = 32;
	localparam int RATE_W  = 32;
	localparam int CUM_W   = 48;
	localparam int IDX_W   = 5;
	localparam int KC_W    = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

	// Word index of the knot count register (byte address 0).
	localparam logic REG_KNOT_COUNT = 1'b0;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [IDX_W-1:0]  entry_index;
		logic [TIME_W-1:0] knot_time;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] query_time;
	} req_t;

	typedef struct packed {
		logic [RATE_W-1:0] hazard;
		logic [CUM_W-1:0]  cumulative;
		logic [IDX_W-1:0]  interval_index;
		logic              out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] knot;
		logic [RATE_W-1:0] rate;
		logic [CUM_W-1:0]  cum;
	} entry_t;

endpackage

// ===== src/phe_accum.sv =====
// Multiply-add of the cumulative hazard: registered rate times time offset,
// then Q32.16 add with saturation. Uses phe_pkg for widths and the limit.
module phe_accum (
	input  logic                       clk,
	input  logic                       en,
	input  logic [phe_pkg::RATE_W-1:0] rate,
	input  logic [phe_pkg::TIME_W-1:0] t_from,
	input  logic [phe_pkg::TIME_W-1:0] t_to,
	input  logic [phe_pkg::CUM_W-1:0]  base,
	output logic [phe_pkg::CUM_W-1:0]  sum
);
	import phe_pkg::*;

	logic [TIME_W-1:0]        dt;
	logic [63:0]              prod_q;
	logic [CUM_W-1:0]         base_q;
	logic [CUM_W:0]           wide;

	// A time running backward contributes nothing.
	assign dt = (t_to >= t_from) ? (t_to - t_from) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 64'(rate) * 64'(dt);
			base_q <= base;
		end
	end

	assign wide = {1'b0, base_q} + {1'b0, prod_q[63:16]};
	assign sum  = wide[CUM_W] ? CUM_MAX : wide[CUM_W-1:0];

endmodule

// ===== src/piecewise_hazard_evaluator.sv =====
// Piecewise-constant hazard evaluator, top level. Depends on phe_pkg and phe_accum.
// One request at a time. Loads of entry zero and ignored loads go straight to done; other
// loads multiply and add. A query makes up to 6 search probes for 32 knots, then multiplies
// and adds, or goes straight to done before the first knot. The next request is accepted
// once the answer is offered, even while it stalls; a stalled answer holds the next in done.
// Reset clears control state and sets knot_count to 1; table contents are undefined.
module piecewise_hazard_evaluator #(
	parameter int MAX_KNOTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  phe_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output phe_pkg::rsp_t               rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [phe_pkg::PADDR_W-1:0] paddr,
	input  logic [phe_pkg::PDATA_W-1:0] pwdata,
	output logic [phe_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import phe_pkg::*;

	localparam int CAP = (MAX_KNOTS < 32) ? MAX_KNOTS : 32;
	localparam int AW  = $clog2(MAX_KNOTS);
	localparam int CW  = $clog2(CAP + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SRCH = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t            state_q;
	logic [KC_W-1:0]   knot_count_q;

	entry_t            mem [MAX_KNOTS];
	entry_t            rd_q;
	logic [AW-1:0]     rd_addr;
	logic              we;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;

	logic              op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] t_q;
	logic [RATE_W-1:0] rate_in_q;
	logic [RATE_W-1:0] hz_q;
	logic [CW-1:0]     lo_q, hi_q, mid_q;
	logic [CW-1:0]     lo_n, hi_n, mid_n, act;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accepted;
	logic              load_ok;
	logic [CUM_W-1:0]  acc_sum;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= KC_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == REG_KNOT_COUNT) begin
			knot_count_q <= pwdata[KC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_KNOT_COUNT)
			prdata = PDATA_W'(knot_count_q);
	end

	// Number of knots searched: zero counts as one, capped at the table size or 32.
	always_comb begin
		if (knot_count_q == '0)
			act = CW'(1);
		else if (32'(knot_count_q) > CAP)
			act = CW'(CAP);
		else
			act = CW'(knot_count_q);
	end

	assign accepted  = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign load_ok   = (32'(req.entry_index) < MAX_KNOTS);

	// One binary search step on the entry just read at mid_q.
	always_comb begin
		if (rd_q.knot <= t_q) begin
			lo_n = mid_q + CW'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = mid_q;
		end
		mid_n = CW'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
	end

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.operation == OP_LOAD)
					rd_addr = AW'(req.entry_index - IDX_W'(1));
				else
					rd_addr = AW'(act >> 1);
			end
			ST_SRCH: begin
				if (lo_n < hi_n)
					rd_addr = AW'(mid_n);
				else
					rd_addr = AW'(lo_n - CW'(1));
			end
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = '0;
		wr_data = '{knot: req.knot_time, rate: req.rate, cum: '0};
		if (state_q == ST_IDLE && accepted && req.operation == OP_LOAD && load_ok &&
				req.entry_index == '0) begin
			we = 1'b1;
		end else if (state_q == ST_ADD && op_q == OP_LOAD) begin
			we      = 1'b1;
			wr_addr = AW'(idx_q);
			wr_data = '{knot: t_q, rate: rate_in_q, cum: acc_sum};
		end
	end

	// Requests never overlap, so a write always lands before the next read of that row.
	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	phe_accum u_accum (
		.clk    (clk),
		.en     (state_q == ST_MUL),
		.rate   (rd_q.rate),
		.t_from (rd_q.knot),
		.t_to   (t_q),
		.base   (rd_q.cum),
		.sum    (acc_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accepted) begin
						if (req.operation == OP_QUERY)
							state_q <= ST_SRCH;
						else if (load_ok && req.entry_index != '0)
							state_q <= ST_MUL;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SRCH: begin
					if (lo_n < hi_n)
						state_q <= ST_SRCH;
					else if (lo_n == '0)
						state_q <= ST_DONE;
					else
						state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request context and result; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accepted) begin
					op_q      <= req.operation;
					idx_q     <= req.entry_index;
					rate_in_q <= req.rate;
					res_q     <= '0;
					lo_q      <= '0;
					hi_q      <= act;
					mid_q     <= act >> 1;
					if (req.operation == OP_QUERY)
						t_q <= req.query_time;
					else
						t_q <= req.knot_time;
				end
			end
			ST_SRCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
				idx_q <= IDX_W'(lo_n - CW'(1));
				if (!(lo_n < hi_n) && lo_n == '0)
					res_q <= '{hazard: '0, cumulative: '0, interval_index: '0,
						out_of_range: 1'b1};
			end
			ST_MUL: hz_q <= rd_q.rate;
			ST_ADD: begin
				if (op_q == OP_QUERY)
					res_q <= '{hazard: hz_q, cumulative: acc_sum, interval_index: idx_q,
						out_of_range: 1'b0};
				else
					res_q <= '0;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall)
					rsp_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for piecewise_hazard_evaluator: a directed table, then
// randomized table loads and queries checked against an in-bench hazard predictor.
// Depends on phe_pkg and the piecewise_hazard_evaluator RTL.
module testbench;
	import phe_pkg::*;

	localparam int MAX_KNOTS    = 32;
	localparam int DRAIN_CYCLES = 16;
	localparam int PRINT_LIMIT  = 40;
	localparam logic [PADDR_W-1:0] KNOT_COUNT_ADDR = PADDR_W'(REG_KNOT_COUNT) << 2;

	localparam rsp_t NO_ANSWER    = '0;
	localparam rsp_t BEFORE_FIRST = '{32'h0, 48'h0, 5'd0, 1'b1};

	typedef enum bit {STEP_REQUEST, STEP_SETTING} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		logic [KC_W-1:0]   count;
		req_t              item;
		bit                typed;
		rsp_t              want;
	} step_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Predicted contents of the knot table and the knot count register.
	logic [TIME_W-1:0]   knot_tab [MAX_KNOTS];
	logic [RATE_W-1:0]   rate_tab [MAX_KNOTS];
	logic [CUM_W-1:0]    cum_tab  [MAX_KNOTS];
	logic [KC_W-1:0]     count_setting = KC_W'(1);
	bit   [31:0]         written_entries = '0;

	rsp_t                answers_due [$];
	bit                  quiet = 1'b0;
	int                  stall_left = 0;
	int                  mismatch_count = 0;
	int                  answers_checked = 0;
	int                  loads_sent = 0;
	int                  queries_sent = 0;
	int                  settings_written = 0;

	step_row_t directed_steps [21] = '{
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd0, 32'h0001_0000, 32'h0002_0000, 32'h0}, 1'b1,
			NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}, 1'b1,
			BEFORE_FIRST},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'h0001_0000}, 1'b1,
			'{32'h0002_0000, 48'h0, 5'd0, 1'b0}},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd1, 32'h0003_0000, 32'h0000_8000, 32'hFFFF_FFFF}, 1'b1,
			NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd2, 32'h0002_0000, 32'h0, 32'h0}, 1'b1, NO_ANSWER},
		'{STEP_SETTING, 6'd0, '0, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'h0005_0000}, 1'b0, NO_ANSWER},
		'{STEP_SETTING, 6'd3, '0, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'h0002_8000}, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'h0003_0000}, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}, 1'b1,
			NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd2, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, NO_ANSWER},
		// Knot two drops back to zero, so the query integrates a full-scale span twice.
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
			'{32'hFFFF_FFFF, CUM_MAX, 5'd2, 1'b0}},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd3, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1, NO_ANSWER},
		'{STEP_SETTING, 6'd4, '0, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0, CUM_MAX, 5'd3, 1'b0}},
		'{STEP_REQUEST, 6'd0, '{OP_QUERY, 5'd0, 32'h0, 32'h0, 32'h0}, 1'b0, NO_ANSWER},
		'{STEP_REQUEST, 6'd0, '{OP_LOAD, 5'd4, 32'h0000_0001, 32'h0000_0001, 32'h0}, 1'b1,
			NO_ANSWER}
	};

	piecewise_hazard_evaluator #(.MAX_KNOTS(MAX_KNOTS)) u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout: requests or answers stopped moving");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [CUM_W-1:0] integrate(input logic [CUM_W-1:0] base,
			input logic [RATE_W-1:0] r, input logic [TIME_W-1:0] from,
			input logic [TIME_W-1:0] upto);
		logic [63:0] span;
		logic [63:0] total;
		span  = (upto >= from) ? 64'(upto - from) : 64'd0;
		total = 64'(base) + ((64'(r) * span) >> 16);
		return (total > 64'(CUM_MAX)) ? CUM_MAX : total[CUM_W-1:0];
	endfunction

	function automatic int searched_knots();
		if (count_setting == 0)
			return 1;
		return (count_setting > MAX_KNOTS) ? MAX_KNOTS : int'(count_setting);
	endfunction

	// Applies one request to the predicted table and returns the answer it should produce.
	function automatic rsp_t hazard_answer(input req_t item);
		rsp_t ans;
		int   lo;
		int   hi;
		int   mid;
		int   at;
		ans = '0;
		if (item.operation == OP_LOAD) begin
			at = item.entry_index;
			if (at < MAX_KNOTS) begin
				knot_tab[at] = item.knot_time;
				rate_tab[at] = item.rate;
				cum_tab[at]  = (at == 0) ? '0 : integrate(cum_tab[at-1], rate_tab[at-1],
					knot_tab[at-1], item.knot_time);
			end
			return ans;
		end
		lo = 0;
		hi = searched_knots();
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (knot_tab[mid] <= item.query_time)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo == 0) begin
			ans.out_of_range = 1'b1;
			return ans;
		end
		ans.hazard         = rate_tab[lo-1];
		ans.cumulative     = integrate(cum_tab[lo-1], rate_tab[lo-1], knot_tab[lo-1],
			item.query_time);
		ans.interval_index = IDX_W'(lo - 1);
		return ans;
	endfunction

	function automatic req_t scrambled_request(input logic op);
		req_t item;
		item.operation   = op;
		item.entry_index = IDX_W'($urandom);
		item.knot_time   = $urandom;
		item.rate        = $urandom;
		item.query_time  = $urandom;
		return item;
	endfunction

	// Spreads values over many magnitudes, with the extremes now and then.
	function automatic logic [31:0] spread_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (answers_due.size() == 0) begin
			report_mismatch($sformatf("answer %p arrived with no request outstanding", got));
			return;
		end
		want = answers_due.pop_front();
		if (got.hazard !== want.hazard)
			report_mismatch($sformatf("answer %0d hazard %h, expected %h",
				answers_checked, got.hazard, want.hazard));
		if (got.cumulative !== want.cumulative)
			report_mismatch($sformatf("answer %0d cumulative %h, expected %h",
				answers_checked, got.cumulative, want.cumulative));
		if (got.interval_index !== want.interval_index)
			report_mismatch($sformatf("answer %0d interval_index %0d, expected %0d",
				answers_checked, got.interval_index, want.interval_index));
		if (got.out_of_range !== want.out_of_range)
			report_mismatch($sformatf("answer %0d out_of_range %b, expected %b",
				answers_checked, got.out_of_range, want.out_of_range));
		answers_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_answer(rsp);
	end

	// After each answer is taken, rsp_stall is held high for a random stretch.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			stall_left = quiet ? 0 : $urandom_range(0, 14);
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Leaves req_valid high after acceptance so a back-to-back request keeps it high.
	task automatic send(input req_t item, input bit typed = 1'b0, input rsp_t want = '0);
		int   gap;
		rsp_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		predicted = hazard_answer(item);
		answers_due.insert(answers_due.size(), typed ? want : predicted);
		if (item.operation == OP_LOAD) begin
			written_entries[item.entry_index] = 1'b1;
			loads_sent++;
		end else begin
			queries_sent++;
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_knot_count(input logic [KC_W-1:0] value);
		logic [PDATA_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= KNOT_COUNT_ADDR;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_setting = value;
		settings_written++;
		// Read the register back straight after the write.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_W'(value))
			report_mismatch($sformatf("knot_count read back %h, expected %h", got, value));
	endtask

	// Loads a non-decreasing table for the new count, then mixes queries with stray reloads.
	task automatic run_phase(input logic [KC_W-1:0] count, input int n_queries);
		int          n;
		int          sh;
		int          j;
		int          at;
		logic [63:0] t;
		logic [32:0] sum;
		req_t        item;
		wait_drained();
		write_knot_count(count);
		quiet = ($urandom_range(0, 3) == 0);
		n  = searched_knots();
		sh = $urandom_range(4, 26);
		t  = $urandom_range(0, 1 << sh);
		for (int i = 0; i < n; i++) begin
			item             = scrambled_request(OP_LOAD);
			item.entry_index = IDX_W'(i);
			item.knot_time   = (t > 64'hFFFF_FFFF) ? '1 : t[31:0];
			item.rate        = spread_value();
			send(item);
			t += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << sh);
		end
		for (int k = 0; k < n_queries; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				do at = $urandom_range(0, MAX_KNOTS - 1);
				while (at != 0 && !written_entries[at-1]);
				item             = scrambled_request(OP_LOAD);
				item.entry_index = IDX_W'(at);
				item.rate        = spread_value();
				send(item);
				continue;
			end
			item = scrambled_request(OP_QUERY);
			j    = $urandom_range(0, n - 1);
			case ($urandom_range(0, 9))
				0: item.query_time = knot_tab[j];
				1: item.query_time = (knot_tab[0] == 0) ? '0 : $urandom_range(0, knot_tab[0] - 1);
				2: ;
				3: item.query_time = '1;
				default: begin
					sum = knot_tab[j] + (spread_value() >> sh[4:0] / 2);
					item.query_time = sum[32] ? '1 : sum[31:0];
				end
			endcase
			send(item);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_SETTING) begin
				wait_drained();
				write_knot_count(directed_steps[i].count);
			end else begin
				send(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
			end
		end

		run_phase(6'd32, 45);
		run_phase(6'd1, 45);
		run_phase(6'd0, 45);
		run_phase(6'd63, 45);
		run_phase(6'd33, 45);
		run_phase(6'd5, 45);
		repeat (6) run_phase(KC_W'($urandom_range(0, 63)), 45);

		wait_drained();
		$display("Covered %0d loads and %0d queries over %0d knot count settings.",
			loads_sent, queries_sent, settings_written);
		$display("Checked %0d answers; %0d mismatches found.", answers_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
